// ----- hw/rtl/dmpq_pkg.sv -----
// Shared types and constants of the dual min-priority queue block.
package dmpq_pkg;

  localparam int unsigned TREES_DEF = 5;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MERGE  = 2'd2,
    CMD_NOP    = 2'd3
  } dmpq_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } dmpq_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_SCAN,
    S_DEL_LAST,
    S_DEL_WB,
    S_MRG_COPY,
    S_MRG_FLUSH
  } dmpq_state_e;

endpackage

// ----- hw/rtl/dual_min_priority_queue_merge.sv -----
// Two min-priority queues of signed keys: insert, delete-minimum and merge.
//
// A command word (command_i, queue_select_i, key_i) is taken at a rising edge
// where start is high and busy is low. Each command gives exactly one result
// word (min_key_o, status_o, count_after_o), shown for one cycle with done_o
// high; the receiver cannot stall it, so it must take the word in that cycle.
// Insert, no-op, every refused command, delete on an empty queue and merge of
// an empty second queue finish at the accepting edge: done_o is high in the
// next cycle and busy stays low, so commands of that kind can follow back to
// back. Delete-minimum over n > 0 keys keeps busy high while the key memory's
// single read port scans one key per cycle, then while the last key is read
// and written into the hole. Merge of m > 0 keys keeps busy high while the
// keys are copied, one key per cycle, through the same read port. The
// result appears in the cycle in which busy falls. Each queue holds up to
// 2^TREES - 1 keys; both live in one memory of 2^(TREES+1) words.
// Reset empties both queues at once; no memory pass is needed.
module dual_min_priority_queue_merge #(
  parameter int unsigned TREES = dmpq_pkg::TREES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           command_i,
  input  logic                                 queue_select_i,
  input  logic signed [dmpq_pkg::KEY_W-1:0]    key_i,
  output logic                                 done_o,
  output logic signed [dmpq_pkg::KEY_W-1:0]    min_key_o,
  output logic [1:0]                           status_o,
  output logic [dmpq_pkg::CNT_OUT_W-1:0]       count_after_o
);

  localparam int unsigned AW = TREES + 1;
  localparam logic [TREES-1:0] CAP = '1;

  dmpq_pkg::dmpq_state_e state_q, state_d;
  dmpq_pkg::dmpq_cmd_e   cmd;

  logic [TREES-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic [TREES-1:0] idx_q, idx_d;
  logic             sel_q, sel_d;
  logic             scan_vld_q, scan_vld_d;
  logic             copy_vld_q, copy_vld_d;
  logic [TREES-1:0] rd_idx_q;
  logic signed [dmpq_pkg::KEY_W-1:0] best_q;
  logic [TREES-1:0] best_idx_q;

  logic             acc;
  logic             sel;
  logic [TREES-1:0] cur_cnt;
  logic [TREES-1:0] last_idx;
  logic [TREES:0]   merge_sum;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [dmpq_pkg::KEY_W-1:0]   ram_wdata, ram_rdata;

  logic                                 res_vld;
  logic signed [dmpq_pkg::KEY_W-1:0]    res_min;
  dmpq_pkg::dmpq_status_e               res_status;
  logic [TREES-1:0]                     res_cnt;

  logic                                 done_q;
  logic signed [dmpq_pkg::KEY_W-1:0]    min_key_q;
  logic [1:0]                           status_q;
  logic [dmpq_pkg::CNT_OUT_W-1:0]       count_q;

  assign busy      = (state_q != dmpq_pkg::S_IDLE);
  assign acc       = start && !busy;
  assign cmd       = dmpq_pkg::dmpq_cmd_e'(command_i);
  assign sel       = busy ? sel_q : queue_select_i;
  assign cur_cnt   = sel ? cnt1_q : cnt0_q;
  assign last_idx  = cur_cnt - 1'b1;
  assign merge_sum = {1'b0, cnt0_q} + {1'b0, cnt1_q};

  dmpq_key_ram #(
    .AW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmpq_pkg::S_IDLE: begin
        if (acc) begin
          if (cmd == dmpq_pkg::CMD_DELETE && cur_cnt != '0) begin
            state_d = dmpq_pkg::S_DEL_SCAN;
          end else if (cmd == dmpq_pkg::CMD_MERGE && merge_sum <= {1'b0, CAP}
                       && cnt1_q != '0) begin
            state_d = dmpq_pkg::S_MRG_COPY;
          end
        end
      end
      dmpq_pkg::S_DEL_SCAN: begin
        if (idx_q == last_idx) begin
          state_d = dmpq_pkg::S_DEL_LAST;
        end
      end
      dmpq_pkg::S_DEL_LAST:  state_d = dmpq_pkg::S_DEL_WB;
      dmpq_pkg::S_DEL_WB:    state_d = dmpq_pkg::S_IDLE;
      dmpq_pkg::S_MRG_COPY: begin
        if (idx_q == cnt1_q - 1'b1) begin
          state_d = dmpq_pkg::S_MRG_FLUSH;
        end
      end
      dmpq_pkg::S_MRG_FLUSH: state_d = dmpq_pkg::S_IDLE;
      default:               state_d = dmpq_pkg::S_IDLE;
    endcase
  end

  // Memory control, counters and result word.
  always_comb begin
    cnt0_d     = cnt0_q;
    cnt1_d     = cnt1_q;
    idx_d      = idx_q;
    sel_d      = sel_q;
    scan_vld_d = 1'b0;
    copy_vld_d = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = {sel_q, idx_q};
    ram_we     = 1'b0;
    ram_waddr  = {sel, cur_cnt};
    ram_wdata  = key_i;
    res_vld    = 1'b0;
    res_min    = '0;
    res_status = dmpq_pkg::STAT_OK;
    res_cnt    = cur_cnt;

    // Copied words land behind the first queue's current keys.
    if (copy_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = {1'b0, cnt0_q + rd_idx_q};
      ram_wdata = ram_rdata;
    end

    case (state_q)
      dmpq_pkg::S_IDLE: begin
        sel_d = queue_select_i;
        idx_d = '0;
        if (acc) begin
          case (cmd)
            dmpq_pkg::CMD_INSERT: begin
              res_vld = 1'b1;
              if (cur_cnt == CAP) begin
                res_status = dmpq_pkg::STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                res_cnt = cur_cnt + 1'b1;
                if (sel) begin
                  cnt1_d = cur_cnt + 1'b1;
                end else begin
                  cnt0_d = cur_cnt + 1'b1;
                end
              end
            end
            dmpq_pkg::CMD_DELETE: begin
              if (cur_cnt == '0) begin
                res_vld    = 1'b1;
                res_status = dmpq_pkg::STAT_EMPTY;
              end
            end
            dmpq_pkg::CMD_MERGE: begin
              res_cnt = cnt0_q;
              if (merge_sum > {1'b0, CAP}) begin
                res_vld    = 1'b1;
                res_status = dmpq_pkg::STAT_FULL;
              end else if (cnt1_q == '0) begin
                res_vld = 1'b1;
              end
            end
            default: begin
              res_vld = 1'b1;
            end
          endcase
        end
      end
      dmpq_pkg::S_DEL_SCAN: begin
        ram_re     = 1'b1;
        scan_vld_d = 1'b1;
        idx_d      = idx_q + 1'b1;
      end
      dmpq_pkg::S_DEL_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = {sel_q, last_idx};
      end
      dmpq_pkg::S_DEL_WB: begin
        // The last key fills the hole; harmless when it is the minimum itself.
        ram_we    = 1'b1;
        ram_waddr = {sel_q, best_idx_q};
        ram_wdata = ram_rdata;
        res_vld   = 1'b1;
        res_min   = best_q;
        res_cnt   = last_idx;
        if (sel_q) begin
          cnt1_d = last_idx;
        end else begin
          cnt0_d = last_idx;
        end
      end
      dmpq_pkg::S_MRG_COPY: begin
        ram_re     = 1'b1;
        ram_raddr  = {1'b1, idx_q};
        copy_vld_d = 1'b1;
        idx_d      = idx_q + 1'b1;
      end
      dmpq_pkg::S_MRG_FLUSH: begin
        res_vld = 1'b1;
        res_cnt = merge_sum[TREES-1:0];
        cnt0_d  = merge_sum[TREES-1:0];
        cnt1_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dmpq_pkg::S_IDLE;
      cnt0_q     <= '0;
      cnt1_q     <= '0;
      idx_q      <= '0;
      sel_q      <= 1'b0;
      scan_vld_q <= 1'b0;
      copy_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt0_q     <= cnt0_d;
      cnt1_q     <= cnt1_d;
      idx_q      <= idx_d;
      sel_q      <= sel_d;
      scan_vld_q <= scan_vld_d;
      copy_vld_q <= copy_vld_d;
      done_q     <= res_vld;
    end
  end

  // Datapath registers: read index tracking, running minimum, result word.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (scan_vld_q && (rd_idx_q == '0 || $signed(ram_rdata) < best_q)) begin
      best_q     <= $signed(ram_rdata);
      best_idx_q <= rd_idx_q;
    end
    if (res_vld) begin
      min_key_q <= res_min;
      status_q  <= res_status;
      count_q   <= dmpq_pkg::CNT_OUT_W'(res_cnt);
    end
  end

  assign done_o        = done_q;
  assign min_key_o     = min_key_q;
  assign status_o      = status_q;
  assign count_after_o = count_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word shown while a command is still running");

  a_fail_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != dmpq_pkg::STAT_OK) |-> (min_key_o == '0))
    else $error("refused command reports a nonzero key");

  a_merge_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmpq_pkg::S_MRG_FLUSH) |=> (cnt1_q == '0))
    else $error("second queue not empty after merge");

  a_hole_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmpq_pkg::S_DEL_WB) |-> (best_idx_q < cur_cnt))
    else $error("minimum position outside the queue");
`endif

endmodule

// ----- hw/rtl/dmpq_key_ram.sv -----
// Key store: one write port and one read port with registered read data.
module dmpq_key_ram #(
  parameter int unsigned AW = dmpq_pkg::TREES_DEF + 1
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [dmpq_pkg::KEY_W-1:0]     wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [dmpq_pkg::KEY_W-1:0]     rdata_o
);

  logic [dmpq_pkg::KEY_W-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- dv/tb_dual_min_priority_queue_merge.sv -----
// Self-checking testbench for the dual min-priority queue: directed and random commands.
`timescale 1ns / 100ps

module tb_dual_min_priority_queue_merge;
  import dmpq_pkg::*;

  localparam int unsigned SLOTS    = 1 << TREES_DEF;
  localparam int unsigned CAPACITY = SLOTS - 1;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    dmpq_cmd_e               cmd;
    logic                    qsel;
    logic signed [KEY_W-1:0] key;
    int unsigned             idle_pct;
    bit                      drain;
  } queue_cmd_t;

  typedef struct {
    logic signed [KEY_W-1:0] min_key;
    dmpq_status_e            status;
    logic [CNT_OUT_W-1:0]    count_after;
  } queue_result_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  command_i = CMD_NOP;
  logic                        queue_select_i = 1'b0;
  logic signed [KEY_W-1:0]     key_i = '0;
  logic                        done_o;
  logic signed [KEY_W-1:0]     min_key_o;
  logic [1:0]                  status_o;
  logic [CNT_OUT_W-1:0]        count_after_o;

  queue_cmd_t    cmd_backlog[$];
  queue_result_t awaited_results[$];
  queue_cmd_t    presented;
  queue_result_t want;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;

  // Shadow copy of both queues; the lower half of the store is the first queue.
  logic signed [KEY_W-1:0] shadow_keys [2*SLOTS];
  int unsigned             first_n = 0;
  int unsigned             second_n = 0;

  dual_min_priority_queue_merge #(.TREES(TREES_DEF)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .queue_select_i (queue_select_i),
    .key_i          (key_i),
    .done_o         (done_o),
    .min_key_o      (min_key_o),
    .status_o       (status_o),
    .count_after_o  (count_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic queue_result_t model_queue_command(queue_cmd_t c);
    queue_result_t r;
    int unsigned   base;
    int unsigned   n;
    int unsigned   best;
    r.min_key = '0;
    r.status  = STAT_OK;
    base = c.qsel ? SLOTS : 0;
    n    = c.qsel ? second_n : first_n;
    case (c.cmd)
      CMD_INSERT: begin
        if (n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_keys[base + n] = c.key;
          n++;
        end
        if (c.qsel) second_n = n; else first_n = n;
        r.count_after = n[CNT_OUT_W-1:0];
      end
      CMD_DELETE: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          best = 0;
          for (int unsigned i = 1; i < n; i++) begin
            if (shadow_keys[base + i] < shadow_keys[base + best]) best = i;
          end
          r.min_key = shadow_keys[base + best];
          n--;
          // The last key fills the hole left by the minimum.
          shadow_keys[base + best] = shadow_keys[base + n];
        end
        if (c.qsel) second_n = n; else first_n = n;
        r.count_after = n[CNT_OUT_W-1:0];
      end
      CMD_MERGE: begin
        if (first_n + second_n > CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int unsigned i = 0; i < second_n; i++) begin
            shadow_keys[first_n + i] = shadow_keys[SLOTS + i];
          end
          first_n  = first_n + second_n;
          second_n = 0;
        end
        r.count_after = first_n[CNT_OUT_W-1:0];
      end
      default: begin
        r.count_after = n[CNT_OUT_W-1:0];
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (fail_count < 40) begin
      $display("[%0t] %s: got %h, want %h", $realtime, what, got, exp_val);
    end
    fail_count++;
  endtask

  task automatic push_cmd(dmpq_cmd_e cmd, logic qsel, logic signed [KEY_W-1:0] key,
                          int unsigned idle_pct, bit drain);
    queue_cmd_t c;
    c.cmd      = cmd;
    c.qsel     = qsel;
    c.key      = key;
    c.idle_pct = idle_pct;
    c.drain    = drain;
    cmd_backlog.push_back(c);
  endtask

  // Driver: a word is taken at an edge with start high and busy low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) awaited_results.push_back(model_queue_command(presented));
      if (start && busy) begin
        // Hold the current word until the block takes it.
      end else if (cmd_backlog.size() != 0
                   && !(cmd_backlog[0].drain && awaited_results.size() != 0)
                   && $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
        presented = cmd_backlog.pop_front();
        start          <= 1'b1;
        command_i      <= presented.cmd;
        queue_select_i <= presented.qsel;
        key_i          <= presented.key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result word with nothing awaited", min_key_o, '0);
      end else begin
        want = awaited_results.pop_front();
        if (min_key_o !== want.min_key) note_mismatch("min_key", min_key_o, want.min_key);
        if (status_o !== want.status) begin
          note_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (count_after_o !== want.count_after) begin
          note_mismatch("count_after", 32'(count_after_o), 32'(want.count_after));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned phase_idle [4];
    int unsigned made;
    int unsigned mode;
    int unsigned style;
    int unsigned burst_len;
    int unsigned roll;
    int unsigned p_ins;
    int unsigned p_del;
    int unsigned p_mrg;
    logic        favored;
    logic        q;
    dmpq_cmd_e   c;
    logic signed [KEY_W-1:0] k;

    phase_idle = '{0, 66, 0, 27};

    // Directed: empty queues, no-ops, keys at both extremes, all keys at the maximum.
    push_cmd(CMD_DELETE, 1'b0, KEY_MAX, 0, 1'b0);
    push_cmd(CMD_DELETE, 1'b1, KEY_MIN, 0, 1'b0);
    push_cmd(CMD_MERGE,  1'b0, '0, 0, 1'b0);
    push_cmd(CMD_NOP,    1'b0, '1, 0, 1'b0);
    push_cmd(CMD_NOP,    1'b1, '0, 0, 1'b0);
    repeat (3) push_cmd(CMD_INSERT, 1'b0, KEY_MAX, 0, 1'b0);
    repeat (4) push_cmd(CMD_DELETE, 1'b0, '0, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b0, KEY_MIN, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b0, '0, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b0, -32'sd1, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b1, KEY_MAX, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b1, KEY_MIN, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b1, 32'sh5555_5555, 0, 1'b0);
    push_cmd(CMD_INSERT, 1'b1, 32'shAAAA_AAAA, 0, 1'b0);
    push_cmd(CMD_MERGE,  1'b1, '0, 0, 1'b0);
    push_cmd(CMD_DELETE, 1'b1, '0, 0, 1'b0);
    push_cmd(CMD_MERGE,  1'b0, '0, 0, 1'b0);
    push_cmd(CMD_DELETE, 1'b0, '0, 0, 1'b0);
    push_cmd(CMD_DELETE, 1'b0, '0, 0, 1'b0);
    push_cmd(CMD_NOP,    1'b0, '0, 0, 1'b0);

    // Random bursts: filling, draining and merge-heavy mixes, each with its own kind of key.
    for (int phase = 0; phase < 4; phase++) begin
      made = 0;
      while (made < 450) begin
        mode      = $urandom_range(2);
        style     = $urandom_range(3);
        burst_len = $urandom_range(60, 10);
        favored   = 1'($urandom_range(1));
        case (mode)
          0: begin p_ins = 85; p_del = 10; p_mrg = 3; end
          1: begin p_ins = 15; p_del = 80; p_mrg = 3; end
          default: begin p_ins = 45; p_del = 25; p_mrg = 25; end
        endcase
        for (int unsigned j = 0; j < burst_len && made < 450; j++) begin
          roll = $urandom_range(99);
          if (roll < p_ins) c = CMD_INSERT;
          else if (roll < p_ins + p_del) c = CMD_DELETE;
          else if (roll < p_ins + p_del + p_mrg) c = CMD_MERGE;
          else c = CMD_NOP;
          if (mode == 2) q = 1'($urandom_range(1));
          else q = ($urandom_range(9) == 0) ? !favored : favored;
          case (style)
            0: k = $urandom;
            1: k = int'($urandom_range(8)) - 4;
            2: begin
              case ($urandom_range(4))
                0: k = KEY_MAX;
                1: k = KEY_MIN;
                2: k = '0;
                3: k = -32'sd1;
                default: k = 32'sd1;
              endcase
            end
            default: k = KEY_MAX;
          endcase
          // The first word of each phase waits until every result is in.
          push_cmd(c, q, k, phase_idle[phase], made == 0);
          made++;
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
